// File: design/tef_pkg.sv
// Package for the TLV event field finder: transaction payload types.
// No dependencies; imported by every design file of the block.
package tef_pkg;

    // Event header is type (2) + length (2); element header likewise.
    localparam logic [15:0] EventHdrBytes = 16'd4;
    localparam logic [15:0] MinEventBytes = 16'd8;
    localparam logic [15:0] MaxOffset     = 16'hFFFF;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] wanted_type;
        logic        last_byte;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [15:0] event_type;
        logic [15:0] payload_offset;
        logic [15:0] payload_length;
        logic [31:0] value_word;
        logic        malformed;
    } t_out_item;

endpackage

// File: design/tlv_event_field_finder.sv
// Top level of the TLV event field finder: parser plus two-deep result queue.
// Depends on tef_pkg and tef_parser.
//
// Takes a serialised event one byte per input transaction and, on the byte
// flagged last_byte, produces one result transaction: event type, whether an
// element of the wanted type was seen, its payload offset/length, its first
// four payload bytes (big-endian, zero filled) and a malformed flag (length
// under 8 or stream shorter than the stated length). wanted_type is sampled
// on the first byte of each event. One byte is accepted every clock cycle
// while input ready is high; the per-byte state update is compares and a
// counter add. Results sit in an output register backed by a skid register,
// so bytes keep flowing while a result waits; input ready drops only when
// both are full.
module tlv_event_field_finder
    import tef_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic      accept;
    logic      push;
    logic      pop;
    t_out_item result;

    logic      r_out_valid;
    t_out_item r_out;
    logic      r_skid_valid;
    t_out_item r_skid;

    // skid empty means there is always room for one more result
    assign o_in_ready  = !r_skid_valid;
    assign accept      = i_in_valid && o_in_ready;
    assign pop         = r_out_valid && i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    tef_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_data),
        .o_push   (push),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop || !r_out_valid) begin
            if (r_skid_valid) begin
                // oldest first: skid moves up, new result refills skid
                r_out       <= r_skid;
                r_out_valid <= 1'b1;
                if (push) begin
                    r_skid <= result;
                end else begin
                    r_skid_valid <= 1'b0;
                end
            end else begin
                r_out_valid <= push;
                r_out       <= result;
            end
        end else if (push) begin
            r_skid       <= result;
            r_skid_valid <= 1'b1;
        end
    end

endmodule

// File: design/tef_parser.sv
// Byte-wise element walker for the TLV event field finder.
// Depends on tef_pkg; instantiated by tlv_event_field_finder.
module tef_parser
    import tef_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_in_item  i_item,
    output logic      o_push,
    output t_out_item o_result
);

    logic [15:0] r_byte_offset, n_byte_offset;
    logic [15:0] r_event_length, n_event_length;
    logic [15:0] r_event_kind, n_event_kind;
    logic [15:0] r_target_type, n_target_type;
    logic [15:0] r_next_elem, n_next_elem;
    logic [15:0] r_elem_type, n_elem_type;
    logic [15:0] r_elem_length, n_elem_length;
    logic        r_match, n_match;
    logic [15:0] r_match_offset, n_match_offset;
    logic [15:0] r_match_length, n_match_length;
    logic [31:0] r_value, n_value;
    logic [2:0]  r_taken, n_taken;

    logic [15:0] off;
    logic [7:0]  b;
    logic [15:0] rel;
    logic [15:0] pay_rel;
    logic [16:0] hdr_end;
    logic [17:0] next_pos;
    logic [15:0] full_len;
    logic        hdr_ok;

    always_comb begin
        off      = r_byte_offset;
        b        = i_item.data_byte;
        rel      = off - r_next_elem;
        pay_rel  = off - r_match_offset;
        hdr_end  = {1'b0, r_next_elem} + {1'b0, EventHdrBytes};
        full_len = {r_elem_length[15:8], b};
        next_pos = {1'b0, hdr_end} + {2'b00, full_len};
        hdr_ok   = (r_event_length >= MinEventBytes)
                && (hdr_end <= {1'b0, r_event_length})
                && (r_elem_type == r_target_type);

        n_event_length = r_event_length;
        n_event_kind   = r_event_kind;
        n_target_type  = r_target_type;
        n_next_elem    = r_next_elem;
        n_elem_type    = r_elem_type;
        n_elem_length  = r_elem_length;
        n_match        = r_match;
        n_match_offset = r_match_offset;
        n_match_length = r_match_length;
        n_value        = r_value;
        n_taken        = r_taken;

        case (off)
            16'd0: begin
                n_target_type = i_item.wanted_type;
                n_event_kind  = {b, 8'h00};
            end
            16'd1: n_event_kind[7:0]   = b;
            16'd2: n_event_length      = {b, 8'h00};
            16'd3: n_event_length[7:0] = b;
            default: begin
                if (off < r_event_length) begin
                    if (off >= r_next_elem && rel < EventHdrBytes) begin
                        case (rel[1:0])
                            2'd0: n_elem_type        = {b, 8'h00};
                            2'd1: n_elem_type[7:0]   = b;
                            2'd2: n_elem_length      = {b, 8'h00};
                            default: begin
                                n_elem_length = full_len;
                                if (!r_match && hdr_ok) begin
                                    n_match        = 1'b1;
                                    n_match_offset = hdr_end[15:0];
                                    n_match_length = full_len;
                                end
                                n_next_elem = (next_pos > {2'b00, MaxOffset})
                                            ? MaxOffset : next_pos[15:0];
                            end
                        endcase
                    end else if (r_match && off >= r_match_offset
                                 && pay_rel < r_match_length && !r_taken[2]) begin
                        case (r_taken[1:0])
                            2'd0: n_value[31:24] = b;
                            2'd1: n_value[23:16] = b;
                            2'd2: n_value[15:8]  = b;
                            default: n_value[7:0] = b;
                        endcase
                        n_taken = r_taken + 3'd1;
                    end
                end
            end
        endcase

        n_byte_offset = (off != MaxOffset) ? off + 16'd1 : off;

        o_push                  = i_accept && i_item.last_byte;
        o_result.found          = n_match;
        o_result.event_type     = n_event_kind;
        o_result.payload_offset = n_match ? n_match_offset : 16'd0;
        o_result.payload_length = n_match ? n_match_length : 16'd0;
        o_result.value_word     = n_match ? n_value : 32'd0;
        o_result.malformed      = (n_event_length < MinEventBytes)
                               || (({1'b0, off} + 17'd1) < {1'b0, n_event_length});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_byte_offset  <= '0;
            r_event_length <= '0;
            r_event_kind   <= '0;
            r_target_type  <= '0;
            r_next_elem    <= EventHdrBytes;
            r_elem_type    <= '0;
            r_elem_length  <= '0;
            r_match        <= 1'b0;
            r_match_offset <= '0;
            r_match_length <= '0;
            r_value        <= '0;
            r_taken        <= '0;
        end else if (i_accept) begin
            r_byte_offset  <= n_byte_offset;
            r_event_length <= n_event_length;
            r_event_kind   <= n_event_kind;
            r_target_type  <= n_target_type;
            r_next_elem    <= n_next_elem;
            r_elem_type    <= n_elem_type;
            r_elem_length  <= n_elem_length;
            r_match        <= n_match;
            r_match_offset <= n_match_offset;
            r_match_length <= n_match_length;
            r_value        <= n_value;
            r_taken        <= n_taken;
        end
    end

endmodule

// File: design/tef_checker.sv
// Port-level assertions for the TLV event field finder, bound to the top.
// Depends on tef_pkg and tlv_event_field_finder.
module tef_checker
    import tef_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result changed while stalled");

    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready && i_in_data.last_byte))
        else $error("result without a last byte");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.found |->
            o_out_data.payload_offset == 16'd0 && o_out_data.payload_length == 16'd0
            && o_out_data.value_word == 32'd0)
        else $error("non-zero fields without a match");

    a_found_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.found |-> o_out_data.payload_offset >= MinEventBytes)
        else $error("match inside event header");

endmodule

bind tlv_event_field_finder tef_checker u_tef_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
